// File: hdl/assert_macros.svh
// Assertion macros used by the datapath of the sparse coefficient store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define SCS_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("scs assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising edge of clock outside reset.
`define SCS_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("scs assertion failed: next-cycle implication");

`endif

// File: hdl/scs_pkg.sv
// Shared constants, codes and command/status types of the sparse coefficient store.
package scs_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 20;

   localparam int OP_BITS          = 3;
   localparam int KEY_FIELD_BITS   = 20;
   localparam int WORD_BITS        = 64;
   localparam int SLOT_FIELD_BITS  = 6;
   localparam int COUNT_FIELD_BITS = 7;

   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   localparam logic [OP_BITS-1:0] OP_LOOKUP = OP_BITS'(0);
   localparam logic [OP_BITS-1:0] OP_WRITE  = OP_BITS'(1);
   localparam logic [OP_BITS-1:0] OP_REMOVE = OP_BITS'(2);
   localparam logic [OP_BITS-1:0] OP_CLEAR  = OP_BITS'(3);
   localparam logic [OP_BITS-1:0] OP_DUMP   = OP_BITS'(4);

   // result word source
   localparam logic [1:0] WSEL_ZERO  = 2'd0;
   localparam logic [1:0] WSEL_REQ   = 2'd1;
   localparam logic [1:0] WSEL_RDATA = 2'd2;
   localparam logic [1:0] WSEL_HOLD  = 2'd3;

   // result slot source
   localparam logic [1:0] SSEL_ZERO = 2'd0;
   localparam logic [1:0] SSEL_HIT  = 2'd1;
   localparam logic [1:0] SSEL_DUMP = 2'd2;

   // word memory read address source
   localparam logic [1:0] RSEL_HIT  = 2'd0;
   localparam logic [1:0] RSEL_LAST = 2'd1;
   localparam logic [1:0] RSEL_DUMP = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic       find;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       hold_load;
      logic       wr_word;
      logic       append;
      logic       move;
      logic       clear;
      logic       dump_rst;
      logic       dump_inc;
      logic       emit;
      logic [1:0] word_sel;
      logic [1:0] slot_sel;
      logic       key_dump;
      logic       found;
      logic       full;
      logic       last;
   } scs_cmd_type;

   typedef struct packed {
      logic hit;
      logic full;
      logic empty;
      logic dump_last;
      logic out_free;
   } scs_status_type;

endpackage

// File: hdl/scs_if.sv
// Request and response channel interfaces of the sparse coefficient store.
interface scs_req_if import scs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_BITS-1:0]        operation;
   logic [KEY_FIELD_BITS-1:0] key;
   logic [WORD_BITS-1:0]      data_word;

   modport source (output valid, output operation, output key, output data_word,
                   input ready);
   modport sink   (input valid, input operation, input key, input data_word,
                   output ready);
endinterface

interface scs_rsp_if import scs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [KEY_FIELD_BITS-1:0]   out_key;
   logic [WORD_BITS-1:0]        out_word;
   logic [SLOT_FIELD_BITS-1:0]  slot_index;
   logic [COUNT_FIELD_BITS-1:0] entry_count;
   logic                        full_error;
   logic                        last_of_run;

   modport source (output valid, output found, output out_key, output out_word,
                   output slot_index, output entry_count, output full_error,
                   output last_of_run, input ready);
   modport sink   (input valid, input found, input out_key, input out_word,
                   input slot_index, input entry_count, input full_error,
                   input last_of_run, output ready);
endinterface

// File: hdl/scs_datapath.sv
// Datapath: key compare cells, word memory, fill count and response register.
`include "assert_macros.svh"

module scs_datapath import scs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [KEY_FIELD_BITS-1:0] req_key,
   input  logic [WORD_BITS-1:0]      req_data_word,
   input  scs_cmd_type               cmd,
   output scs_status_type            status,
   scs_rsp_if.source                 rsp
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic [COUNT_BITS-1:0] fill_ff;
   logic [COUNT_BITS-1:0] fill_in;
   logic [COUNT_BITS-1:0] last_count;
   logic [SLOT_BITS-1:0]  last_slot;
   logic [SLOT_BITS-1:0]  fill_slot;

   logic [KEY_BITS-1:0]   key_mem_ff [CAPACITY];
   logic [WORD_BITS-1:0]  word_mem [CAPACITY];
   logic [WORD_BITS-1:0]  rdata_ff;
   logic [WORD_BITS-1:0]  hold_ff;

   logic [CAPACITY-1:0]   match;
   logic [SLOT_BITS-1:0]  match_slot;
   logic                  hit_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [SLOT_BITS-1:0]  dump_ff;

   logic [SLOT_BITS-1:0]  rd_addr;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  mem_we;

   logic [WORD_BITS-1:0]  word_pick;
   logic [SLOT_BITS-1:0]  slot_pick;
   logic [KEY_BITS-1:0]   key_pick;

   logic                        rsp_valid_ff;
   logic                        found_ff;
   logic [KEY_FIELD_BITS-1:0]   out_key_ff;
   logic [WORD_BITS-1:0]        out_word_ff;
   logic [SLOT_FIELD_BITS-1:0]  slot_index_ff;
   logic [COUNT_FIELD_BITS-1:0] entry_count_ff;
   logic                        full_error_ff;
   logic                        last_ff;

   assign last_count = fill_ff - COUNT_BITS'(1);
   assign last_slot  = last_count[SLOT_BITS-1:0];
   assign fill_slot  = fill_ff[SLOT_BITS-1:0];

   // request holding registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff  <= KEY_BITS'(req_key);
         word_ff <= req_data_word;
      end
   end

   // parallel compare over the occupied slots; keys are unique there, so an OR
   // of the matching slot numbers gives the hit slot
   always_comb begin
      match      = '0;
      match_slot = '0;
      for (int s = 0; s < CAPACITY; s++) begin
         if ((COUNT_BITS'(s) < fill_ff) && (key_mem_ff[s] == key_ff)) begin
            match[s]   = 1'b1;
            match_slot = match_slot | SLOT_BITS'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.find) begin
         hit_ff  <= |match;
         slot_ff <= match_slot;
      end else if (cmd.append) begin
         slot_ff <= fill_slot;
      end
   end

   // key cells
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         key_mem_ff[fill_slot] <= key_ff;
      end else if (cmd.move) begin
         key_mem_ff[slot_ff] <= key_mem_ff[last_slot];
      end
   end

   // word memory: one write port, one registered read port
   always_comb begin
      unique case (cmd.rd_sel)
         RSEL_HIT:  rd_addr = slot_ff;
         RSEL_LAST: rd_addr = last_slot;
         RSEL_DUMP: rd_addr = dump_ff;
         default:   rd_addr = slot_ff;
      endcase
   end

   assign mem_we  = cmd.wr_word | cmd.append | cmd.move;
   assign wr_addr = cmd.append ? fill_slot : slot_ff;
   assign wr_data = cmd.move ? rdata_ff : word_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= word_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_load) begin
         hold_ff <= rdata_ff;
      end
   end

   always_comb begin
      priority if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.append) begin
         fill_in = fill_ff + COUNT_BITS'(1);
      end else if (cmd.move) begin
         fill_in = last_count;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dump_rst) begin
         dump_ff <= '0;
      end else if (cmd.dump_inc) begin
         dump_ff <= dump_ff + SLOT_BITS'(1);
      end
   end

   // response register
   always_comb begin
      unique case (cmd.word_sel)
         WSEL_ZERO:  word_pick = '0;
         WSEL_REQ:   word_pick = word_ff;
         WSEL_RDATA: word_pick = rdata_ff;
         WSEL_HOLD:  word_pick = hold_ff;
      endcase
      unique case (cmd.slot_sel)
         SSEL_ZERO: slot_pick = '0;
         SSEL_HIT:  slot_pick = slot_ff;
         SSEL_DUMP: slot_pick = dump_ff;
         default:   slot_pick = '0;
      endcase
      key_pick = cmd.key_dump ? key_mem_ff[dump_ff] : key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         found_ff       <= cmd.found;
         out_key_ff     <= KEY_FIELD_BITS'(key_pick);
         out_word_ff    <= word_pick;
         slot_index_ff  <= SLOT_FIELD_BITS'(slot_pick);
         entry_count_ff <= COUNT_FIELD_BITS'(fill_ff);
         full_error_ff  <= cmd.full;
         last_ff        <= cmd.last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = found_ff;
   assign rsp.out_key     = out_key_ff;
   assign rsp.out_word    = out_word_ff;
   assign rsp.slot_index  = slot_index_ff;
   assign rsp.entry_count = entry_count_ff;
   assign rsp.full_error  = full_error_ff;
   assign rsp.last_of_run = last_ff;

   always_comb begin
      status.hit       = hit_ff;
      status.full      = (fill_ff == COUNT_BITS'(CAPACITY));
      status.empty     = (fill_ff == '0);
      status.dump_last = ((COUNT_BITS'(dump_ff) + COUNT_BITS'(1)) == fill_ff);
      status.out_free  = !rsp_valid_ff || rsp.ready;
   end

   `SCS_ASSERT_IMPLY(a_append_room, cmd.append, fill_ff < COUNT_BITS'(CAPACITY))
   `SCS_ASSERT_IMPLY(a_move_hit, cmd.move, hit_ff && (fill_ff != '0))
   `SCS_ASSERT_IMPLY(a_emit_room, cmd.emit, !rsp_valid_ff || rsp.ready)
   `SCS_ASSERT_NEXT(a_append_count, cmd.append, fill_ff == $past(fill_ff) + COUNT_BITS'(1))

endmodule

// File: hdl/scs_ctrl.sv
// Controller state machine: sequences find, memory access and response per transaction.
module scs_ctrl import scs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [OP_BITS-1:0] req_operation,
   output logic               req_ready,
   input  scs_status_type     status,
   output scs_cmd_type        cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_FIND      = 3'd1;
   localparam logic [2:0] S_EXEC      = 3'd2;
   localparam logic [2:0] S_RM_HOLD   = 3'd3;
   localparam logic [2:0] S_RM_MOVE   = 3'd4;
   localparam logic [2:0] S_EMIT      = 3'd5;
   localparam logic [2:0] S_DUMP_RD   = 3'd6;
   localparam logic [2:0] S_DUMP_EMIT = 3'd7;

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   logic [OP_BITS-1:0] op_ff;
   logic [OP_BITS-1:0] op_in;
   logic               refuse_ff;
   logic               refuse_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      op_in     = op_ff;
      refuse_in = refuse_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               op_in        = req_operation;
               unique case (req_operation)
                  OP_LOOKUP, OP_WRITE, OP_REMOVE: begin
                     state_in = S_FIND;
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_EMIT;
                  end
                  OP_DUMP: begin
                     // empty dump yields nothing
                     if (!status.empty) begin
                        cmd.dump_rst = 1'b1;
                        state_in     = S_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FIND: begin
            cmd.find  = 1'b1;
            refuse_in = 1'b0;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_EMIT;
            unique case (op_ff)
               OP_LOOKUP: begin
                  cmd.rd_en  = status.hit;
                  cmd.rd_sel = RSEL_HIT;
               end
               OP_WRITE: begin
                  priority if (status.hit) begin
                     cmd.wr_word = 1'b1;
                  end else if (status.full) begin
                     refuse_in = 1'b1;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (status.hit) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RSEL_HIT;
                     state_in   = S_RM_HOLD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RM_HOLD: begin
            // keep the removed word, fetch the last slot's word
            cmd.hold_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RSEL_LAST;
            state_in      = S_RM_MOVE;
         end
         S_RM_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.last = 1'b1;
            unique case (op_ff)
               OP_LOOKUP: begin
                  cmd.found    = status.hit;
                  cmd.word_sel = status.hit ? WSEL_RDATA : WSEL_ZERO;
                  cmd.slot_sel = status.hit ? SSEL_HIT : SSEL_ZERO;
               end
               OP_WRITE: begin
                  cmd.found    = status.hit;
                  cmd.full     = refuse_ff;
                  cmd.word_sel = refuse_ff ? WSEL_ZERO : WSEL_REQ;
                  cmd.slot_sel = refuse_ff ? SSEL_ZERO : SSEL_HIT;
               end
               OP_REMOVE: begin
                  cmd.found    = status.hit;
                  cmd.word_sel = status.hit ? WSEL_HOLD : WSEL_ZERO;
                  cmd.slot_sel = status.hit ? SSEL_HIT : SSEL_ZERO;
               end
               default: begin
                  cmd.word_sel = WSEL_ZERO;
                  cmd.slot_sel = SSEL_ZERO;
               end
            endcase
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RSEL_DUMP;
            state_in   = S_DUMP_EMIT;
         end
         S_DUMP_EMIT: begin
            cmd.found    = 1'b1;
            cmd.key_dump = 1'b1;
            cmd.word_sel = WSEL_RDATA;
            cmd.slot_sel = SSEL_DUMP;
            cmd.last     = status.dump_last;
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.dump_inc = 1'b1;
               state_in     = status.dump_last ? S_IDLE : S_DUMP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         refuse_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         refuse_ff <= refuse_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

// File: hdl/sparse_coefficient_store.sv
// Sparse coefficient store: one transaction in flight at a time. A request is taken
// only while the block is idle; lookup and write step from acceptance through a
// registered key compare and a memory access or update to the response being loaded.
// A remove that finds its key adds a hold step and a move step because the single-read-port
// word memory is read twice (the removed word, then the last slot's word); a remove
// of an absent key takes the steps of a lookup. Clear goes from acceptance straight
// to its response, and dump makes one memory read and one response per stored entry.
// An unused operation code or a dump of an empty store is absorbed in the accepting
// cycle. A stalled response channel adds cycles only where a response is waiting to
// be loaded. The response register holds one finished result while the next request is taken.
module sparse_coefficient_store import scs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   scs_req_if.sink   req,
   scs_rsp_if.source rsp
);

   scs_cmd_type    cmd;
   scs_status_type status;

   scs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_operation (req.operation),
      .req_ready     (req.ready),
      .status        (status),
      .cmd           (cmd)
   );

   scs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_key       (req.key),
      .req_data_word (req.data_word),
      .cmd           (cmd),
      .status        (status),
      .rsp           (rsp)
   );

endmodule
